@@ rtl/dmnc_pkg.sv @@
// shared types, codes and constants for the density matrix noise channel
// no dependencies; the top, dmnc_regs and dmnc_mac refer to it by scoped names, the testbench imports it
`default_nettype none

package dmnc_pkg;

    localparam int MAX_QUBITS_DEF   = 4;
    localparam int ELEMENT_BITS_DEF = 32;

    localparam int FACTOR_W     = 17;
    localparam int FACTOR_SHIFT = 16;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int LSH_W   = 3;
    localparam int RSH_W   = 5;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_APPLY = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DEPOL = 2'd0,
        KIND_AMP   = 2'd1,
        KIND_PHASE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_CHANNEL_KIND    = 3'd0,
        REG_QUBIT_COUNT     = 3'd1,
        REG_TARGET_QUBIT    = 3'd2,
        REG_STRENGTH        = 3'd3,
        REG_COHERENCE_SCALE = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_TR_RD,
        ST_TR_ACC,
        ST_TR_SAT,
        ST_EL_RD,
        ST_EL_LD,
        ST_PT_LD,
        ST_ISSUE0,
        ST_ISSUE1,
        ST_DRAIN,
        ST_CAPTURE,
        ST_DONE
    } t_state;

    // how one entry is updated by the current channel
    typedef enum logic [2:0] {
        CL_SKIP,
        CL_DIAG,
        CL_OMP,
        CL_CS,
        CL_LOW
    } t_cls;

    typedef struct packed {
        logic [1:0]          channel_kind;
        logic [2:0]          qubit_count;
        logic [1:0]          target_qubit;
        logic [FACTOR_W-1:0] strength;
        logic [FACTOR_W-1:0] coherence_scale;
    } t_cfg;

    typedef struct packed {
        logic             issue;
        logic             clear;
        logic [LSH_W-1:0] lsh;
    } t_mac_ctl;

endpackage

`default_nettype wire

@@ rtl/dmnc_cmd_if.sv @@
// command channel: one word is a write, read or apply request
// depends on nothing
`default_nettype none

interface dmnc_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [3:0]         row;
    logic [3:0]         column;
    logic signed [31:0] real_in;
    logic signed [31:0] imag_in;

    modport source (output valid, command, row, column, real_in, imag_in, input ready);
    modport sink (input valid, command, row, column, real_in, imag_in, output ready);
endinterface

`default_nettype wire

@@ rtl/dmnc_res_if.sv @@
// result channel: one word per accepted command
// depends on nothing
`default_nettype none

interface dmnc_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] real_out;
    logic signed [31:0] imag_out;
    logic signed [31:0] trace_out;
    logic               status;

    modport source (output valid, real_out, imag_out, trace_out, status, input ready);
    modport sink (input valid, real_out, imag_out, trace_out, status, output ready);
endinterface

`default_nettype wire

@@ rtl/density_matrix_noise_channel.sv @@
// Density matrix noise channel. A write or read command takes one word and returns one
// result word from ST_DONE, a read after ST_READ; the block then goes back to idle
// before it takes the next command. An apply walks the matrix in place through one
// shared multiply-accumulate unit and an element store with one write and one read
// port: a changed entry passes ST_EL_RD, ST_EL_LD, ST_PT_LD (when amplitude damping
// adds in its partner entry), then ST_ISSUE0, ST_ISSUE1, ST_DRAIN and ST_CAPTURE for
// its real and again for its imaginary part, an untouched entry only ST_EL_RD;
// depolarizing first sums the diagonal in ST_TR_RD and ST_TR_ACC. The command channel
// is not ready during the apply. Elements are signed with ELEMENT_BITS-2 fraction bits,
// factors unsigned Q1.16; results round to nearest and saturate. Configuration goes
// through the apb port and may be changed only while no command is in flight.
// depends on dmnc_pkg, dmnc_cmd_if, dmnc_res_if, dmnc_regs, dmnc_store, dmnc_mac
`default_nettype none

module density_matrix_noise_channel #(
    parameter int MAX_QUBITS   = dmnc_pkg::MAX_QUBITS_DEF,
    parameter int ELEMENT_BITS = dmnc_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    dmnc_cmd_if.sink                          i_cmd,
    dmnc_res_if.source                        o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dmnc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dmnc_pkg::PDATA_W-1:0] pwdata,
    output logic      [dmnc_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int QW = MAX_QUBITS;
    localparam int EB = ELEMENT_BITS;
    localparam int TW = EB + QW;
    localparam int FW = dmnc_pkg::FACTOR_W;
    localparam logic signed [32:0] W_MAX = 33'((64'sd1 <<< (EB - 1)) - 64'sd1);
    localparam logic signed [32:0] W_MIN = -W_MAX - 33'sd1;
    localparam logic signed [TW-1:0] T_MAX = TW'((64'sd1 <<< (EB - 1)) - 64'sd1);
    localparam logic signed [TW-1:0] T_MIN = -T_MAX - TW'(1);

    function automatic logic signed [EB-1:0] sat_word(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        if (w > W_MAX) begin
            return EB'(W_MAX);
        end else if (w < W_MIN) begin
            return EB'(W_MIN);
        end
        return v[EB-1:0];
    endfunction

    function automatic logic signed [EB-1:0] sat_trace(input logic signed [TW-1:0] v);
        if (v > T_MAX) begin
            return EB'(T_MAX);
        end else if (v < T_MIN) begin
            return EB'(T_MIN);
        end
        return v[EB-1:0];
    endfunction

    dmnc_pkg::t_cfg   cfg;
    dmnc_pkg::t_state r_state;
    dmnc_pkg::t_state n_state;
    dmnc_pkg::t_cls   r_cls;
    dmnc_pkg::t_cls   cls_cur;
    dmnc_pkg::t_mac_ctl mac_ctl;

    logic                  accept;
    logic                  out_free;
    logic [2:0]            n_used;
    logic [QW-1:0]         dim_m1;
    logic [QW-1:0]         tmask;
    logic                  tbad;
    logic                  last_entry;
    logic                  bi;
    logic                  bj;
    logic [FW-1:0]         g17;
    logic [FW-1:0]         cs17;
    logic [FW-1:0]         omp17;
    logic [QW-1:0]         in_row;
    logic [QW-1:0]         in_col;

    logic                  st_we;
    logic [2*QW-1:0]       st_waddr;
    logic [2*QW-1:0]       st_raddr;
    logic [2*EB-1:0]       st_wdata;
    logic [2*EB-1:0]       st_rdata;
    logic signed [EB-1:0]  rd_re;
    logic signed [EB-1:0]  rd_im;

    logic signed [EB-1:0]  mac_x;
    logic signed [FW:0]    mac_f;
    logic [dmnc_pkg::RSH_W-1:0] mac_rsh;
    logic signed [EB-1:0]  mac_res;
    logic                  re_diag;

    logic [QW-1:0]         r_row;
    logic [QW-1:0]         r_col;
    logic                  r_comp;
    logic signed [EB-1:0]  r_e_re;
    logic signed [EB-1:0]  r_e_im;
    logic signed [EB-1:0]  r_f_re;
    logic signed [EB-1:0]  r_f_im;
    logic signed [TW-1:0]  r_trace_acc;
    logic signed [EB-1:0]  r_trace;
    logic signed [EB-1:0]  r_new_re;
    logic signed [EB-1:0]  r_res_re;
    logic signed [EB-1:0]  r_res_im;
    logic signed [EB-1:0]  r_res_tr;
    logic                  r_res_st;
    logic                  r_out_valid;
    logic signed [31:0]    r_out_re;
    logic signed [31:0]    r_out_im;
    logic signed [31:0]    r_out_tr;
    logic                  r_out_st;

    dmnc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dmnc_store #(
        .ADDR_W (2 * QW),
        .DATA_W (2 * EB)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    dmnc_mac #(
        .MAX_QUBITS   (MAX_QUBITS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_x      (mac_x),
        .i_f      (mac_f),
        .i_rsh    (mac_rsh),
        .o_result (mac_res)
    );

    // configuration derived values
    assign n_used = (cfg.qubit_count > 3'(MAX_QUBITS)) ? 3'(MAX_QUBITS) : cfg.qubit_count;
    assign dim_m1 = QW'((32'd1 << n_used) - 32'd1);
    assign tmask  = QW'(4'b0001 << cfg.target_qubit);
    assign tbad   = ({1'b0, cfg.target_qubit} >= n_used);
    assign g17    = (cfg.strength > dmnc_pkg::FACTOR_ONE) ? dmnc_pkg::FACTOR_ONE : cfg.strength;
    assign cs17   = (cfg.coherence_scale > dmnc_pkg::FACTOR_ONE) ?
                    dmnc_pkg::FACTOR_ONE : cfg.coherence_scale;
    assign omp17  = dmnc_pkg::FACTOR_ONE - g17;

    assign in_row = QW'(i_cmd.row) & dim_m1;
    assign in_col = QW'(i_cmd.column) & dim_m1;

    assign i_cmd.ready = (r_state == dmnc_pkg::ST_IDLE);
    assign accept      = i_cmd.valid & i_cmd.ready;
    assign out_free    = !r_out_valid | o_res.ready;

    assign rd_re = st_rdata[2*EB-1 -: EB];
    assign rd_im = st_rdata[EB-1:0];

    assign last_entry = (r_row == dim_m1) && (r_col == dim_m1);
    assign bi         = |(r_row & tmask);
    assign bj         = |(r_col & tmask);
    assign re_diag    = (r_cls == dmnc_pkg::CL_DIAG) && !r_comp;

    always_comb begin
        case (dmnc_pkg::t_kind'(cfg.channel_kind))
            dmnc_pkg::KIND_DEPOL: begin
                cls_cur = (r_row == r_col) ? dmnc_pkg::CL_DIAG : dmnc_pkg::CL_OMP;
            end
            dmnc_pkg::KIND_AMP: begin
                if (bi != bj) begin
                    cls_cur = dmnc_pkg::CL_CS;
                end else if (!bi) begin
                    cls_cur = dmnc_pkg::CL_LOW;
                end else begin
                    cls_cur = dmnc_pkg::CL_OMP;
                end
            end
            dmnc_pkg::KIND_PHASE: begin
                cls_cur = (bi != bj) ? dmnc_pkg::CL_CS : dmnc_pkg::CL_SKIP;
            end
            default: begin
                cls_cur = dmnc_pkg::CL_SKIP;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dmnc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (dmnc_pkg::t_cmd'(i_cmd.command))
                        dmnc_pkg::CMD_READ: n_state = dmnc_pkg::ST_READ;
                        dmnc_pkg::CMD_APPLY: begin
                            case (dmnc_pkg::t_kind'(cfg.channel_kind))
                                dmnc_pkg::KIND_DEPOL: n_state = dmnc_pkg::ST_TR_RD;
                                dmnc_pkg::KIND_AMP,
                                dmnc_pkg::KIND_PHASE: begin
                                    n_state = tbad ? dmnc_pkg::ST_DONE : dmnc_pkg::ST_EL_RD;
                                end
                                default: n_state = dmnc_pkg::ST_DONE;
                            endcase
                        end
                        default: n_state = dmnc_pkg::ST_DONE;
                    endcase
                end
            end
            dmnc_pkg::ST_READ:   n_state = dmnc_pkg::ST_DONE;
            dmnc_pkg::ST_TR_RD:  n_state = dmnc_pkg::ST_TR_ACC;
            dmnc_pkg::ST_TR_ACC: begin
                n_state = (r_row == dim_m1) ? dmnc_pkg::ST_TR_SAT : dmnc_pkg::ST_TR_RD;
            end
            dmnc_pkg::ST_TR_SAT: n_state = dmnc_pkg::ST_EL_RD;
            dmnc_pkg::ST_EL_RD: begin
                if (cls_cur != dmnc_pkg::CL_SKIP) begin
                    n_state = dmnc_pkg::ST_EL_LD;
                end else if (last_entry) begin
                    n_state = dmnc_pkg::ST_DONE;
                end
            end
            dmnc_pkg::ST_EL_LD: begin
                n_state = (r_cls == dmnc_pkg::CL_LOW) ? dmnc_pkg::ST_PT_LD : dmnc_pkg::ST_ISSUE0;
            end
            dmnc_pkg::ST_PT_LD:  n_state = dmnc_pkg::ST_ISSUE0;
            dmnc_pkg::ST_ISSUE0: n_state = dmnc_pkg::ST_ISSUE1;
            dmnc_pkg::ST_ISSUE1: n_state = dmnc_pkg::ST_DRAIN;
            dmnc_pkg::ST_DRAIN:  n_state = dmnc_pkg::ST_CAPTURE;
            dmnc_pkg::ST_CAPTURE: begin
                if (!r_comp) begin
                    n_state = dmnc_pkg::ST_ISSUE0;
                end else begin
                    n_state = last_entry ? dmnc_pkg::ST_DONE : dmnc_pkg::ST_EL_RD;
                end
            end
            dmnc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = dmnc_pkg::ST_IDLE;
                end
            end
            default: n_state = dmnc_pkg::ST_IDLE;
        endcase
    end

    // store and mac controls
    always_comb begin
        st_we    = 1'b0;
        st_waddr = {r_row, r_col};
        st_wdata = {r_new_re, mac_res};
        st_raddr = {r_row, r_col};
        mac_ctl  = '0;
        mac_x    = r_comp ? r_e_im : r_e_re;
        mac_f    = {1'b0, omp17};
        mac_rsh  = re_diag ? dmnc_pkg::RSH_W'(dmnc_pkg::FACTOR_SHIFT) + dmnc_pkg::RSH_W'(n_used)
                           : dmnc_pkg::RSH_W'(dmnc_pkg::FACTOR_SHIFT);
        case (r_state)
            dmnc_pkg::ST_IDLE: begin
                st_raddr = {in_row, in_col};
                if (accept && (dmnc_pkg::t_cmd'(i_cmd.command) == dmnc_pkg::CMD_WRITE)) begin
                    st_we    = 1'b1;
                    st_waddr = {in_row, in_col};
                    st_wdata = {sat_word(i_cmd.real_in), sat_word(i_cmd.imag_in)};
                end
            end
            dmnc_pkg::ST_TR_RD: begin
                st_raddr = {r_row, r_row};
            end
            dmnc_pkg::ST_EL_LD: begin
                // partner entry with the target bit set in row and column
                st_raddr = {r_row | tmask, r_col | tmask};
            end
            dmnc_pkg::ST_ISSUE0: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.clear = 1'b1;
                mac_ctl.lsh   = re_diag ? n_used : '0;
                case (r_cls)
                    dmnc_pkg::CL_CS:  mac_f = {1'b0, cs17};
                    dmnc_pkg::CL_LOW: mac_f = {1'b0, dmnc_pkg::FACTOR_ONE};
                    default:          mac_f = {1'b0, omp17};
                endcase
            end
            dmnc_pkg::ST_ISSUE1: begin
                mac_ctl.issue = re_diag || (r_cls == dmnc_pkg::CL_LOW);
                mac_f         = {1'b0, g17};
                if (re_diag) begin
                    mac_x = r_trace;
                end else begin
                    mac_x = r_comp ? r_f_im : r_f_re;
                end
            end
            dmnc_pkg::ST_CAPTURE: begin
                st_we = r_comp;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmnc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == dmnc_pkg::ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dmnc_pkg::ST_IDLE: begin
                if (accept) begin
                    r_res_re    <= '0;
                    r_res_im    <= '0;
                    r_res_tr    <= '0;
                    r_res_st    <= (dmnc_pkg::t_cmd'(i_cmd.command) == dmnc_pkg::CMD_APPLY) &&
                                   ((dmnc_pkg::t_kind'(cfg.channel_kind) == dmnc_pkg::KIND_AMP) ||
                                    (dmnc_pkg::t_kind'(cfg.channel_kind) == dmnc_pkg::KIND_PHASE)) &&
                                   tbad;
                    r_row       <= '0;
                    r_col       <= '0;
                    r_comp      <= 1'b0;
                    r_trace_acc <= '0;
                end
            end
            dmnc_pkg::ST_READ: begin
                r_res_re <= rd_re;
                r_res_im <= rd_im;
            end
            dmnc_pkg::ST_TR_ACC: begin
                r_trace_acc <= r_trace_acc + TW'(rd_re);
                if (r_row != dim_m1) begin
                    r_row <= r_row + QW'(1);
                end
            end
            dmnc_pkg::ST_TR_SAT: begin
                r_trace  <= sat_trace(r_trace_acc);
                r_res_tr <= sat_trace(r_trace_acc);
                r_row    <= '0;
            end
            dmnc_pkg::ST_EL_RD: begin
                r_cls  <= cls_cur;
                r_comp <= 1'b0;
                if (cls_cur == dmnc_pkg::CL_SKIP) begin
                    if (r_col == dim_m1) begin
                        r_col <= '0;
                        r_row <= r_row + QW'(1);
                    end else begin
                        r_col <= r_col + QW'(1);
                    end
                end
            end
            dmnc_pkg::ST_EL_LD: begin
                r_e_re <= rd_re;
                r_e_im <= rd_im;
            end
            dmnc_pkg::ST_PT_LD: begin
                r_f_re <= rd_re;
                r_f_im <= rd_im;
            end
            dmnc_pkg::ST_CAPTURE: begin
                if (!r_comp) begin
                    r_new_re <= mac_res;
                    r_comp   <= 1'b1;
                end else begin
                    r_comp <= 1'b0;
                    if (r_col == dim_m1) begin
                        r_col <= '0;
                        r_row <= r_row + QW'(1);
                    end else begin
                        r_col <= r_col + QW'(1);
                    end
                end
            end
            dmnc_pkg::ST_DONE: begin
                if (out_free) begin
                    r_out_re <= 32'(r_res_re);
                    r_out_im <= 32'(r_res_im);
                    r_out_tr <= 32'(r_res_tr);
                    r_out_st <= r_res_st;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.real_out  = r_out_re;
    assign o_res.imag_out  = r_out_im;
    assign o_res.trace_out = r_out_tr;
    assign o_res.status    = r_out_st;

endmodule

`default_nettype wire

@@ rtl/dmnc_regs.sv @@
// apb configuration registers of the noise channel
// depends on dmnc_pkg
`default_nettype none

module dmnc_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dmnc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dmnc_pkg::PDATA_W-1:0] pwdata,
    output logic      [dmnc_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output dmnc_pkg::t_cfg                    o_cfg
);

    dmnc_pkg::t_cfg r_cfg;
    dmnc_pkg::t_reg reg_sel;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_sel = dmnc_pkg::t_reg'(paddr[dmnc_pkg::PADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_kind    <= 2'd0;
            r_cfg.qubit_count     <= 3'd1;
            r_cfg.target_qubit    <= 2'd0;
            r_cfg.strength        <= '0;
            r_cfg.coherence_scale <= dmnc_pkg::FACTOR_ONE;
        end else if (wr_en) begin
            case (reg_sel)
                dmnc_pkg::REG_CHANNEL_KIND: begin
                    r_cfg.channel_kind <= pwdata[1:0];
                end
                dmnc_pkg::REG_QUBIT_COUNT: begin
                    r_cfg.qubit_count <= pwdata[2:0];
                end
                dmnc_pkg::REG_TARGET_QUBIT: begin
                    r_cfg.target_qubit <= pwdata[1:0];
                end
                dmnc_pkg::REG_STRENGTH: begin
                    r_cfg.strength <= pwdata[dmnc_pkg::FACTOR_W-1:0];
                end
                dmnc_pkg::REG_COHERENCE_SCALE: begin
                    r_cfg.coherence_scale <= pwdata[dmnc_pkg::FACTOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            dmnc_pkg::REG_CHANNEL_KIND:    prdata = dmnc_pkg::PDATA_W'(r_cfg.channel_kind);
            dmnc_pkg::REG_QUBIT_COUNT:     prdata = dmnc_pkg::PDATA_W'(r_cfg.qubit_count);
            dmnc_pkg::REG_TARGET_QUBIT:    prdata = dmnc_pkg::PDATA_W'(r_cfg.target_qubit);
            dmnc_pkg::REG_STRENGTH:        prdata = dmnc_pkg::PDATA_W'(r_cfg.strength);
            dmnc_pkg::REG_COHERENCE_SCALE: prdata = dmnc_pkg::PDATA_W'(r_cfg.coherence_scale);
            default:                       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dmnc_store.sv @@
// matrix element store: one write port, one registered read port
// depends on nothing; contents are undefined until written
`default_nettype none

module dmnc_store #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/dmnc_mac.sv @@
// shared multiply-accumulate unit with round-to-nearest and saturation
// depends on dmnc_pkg; product register, then accumulator register
`default_nettype none

module dmnc_mac #(
    parameter int MAX_QUBITS   = dmnc_pkg::MAX_QUBITS_DEF,
    parameter int ELEMENT_BITS = dmnc_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  dmnc_pkg::t_mac_ctl                     i_ctl,
    input  wire logic signed [ELEMENT_BITS-1:0]    i_x,
    input  wire logic signed [dmnc_pkg::FACTOR_W:0] i_f,
    input  wire logic        [dmnc_pkg::RSH_W-1:0] i_rsh,
    output logic signed      [ELEMENT_BITS-1:0]    o_result
);

    localparam int PW = ELEMENT_BITS + dmnc_pkg::FACTOR_W + 1;
    localparam int AW = PW + MAX_QUBITS + 1;
    localparam logic signed [AW-1:0] E_MAX =
        AW'((64'sd1 <<< (ELEMENT_BITS - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] E_MIN = -E_MAX - AW'(1);

    logic signed [PW-1:0]             r_prod;
    logic                             r_valid;
    logic                             r_clear;
    logic        [dmnc_pkg::LSH_W-1:0] r_lsh;
    logic signed [AW-1:0]             r_acc;
    logic signed [AW-1:0]             prod_sh;
    logic signed [AW-1:0]             half;
    logic signed [AW-1:0]             rounded;
    logic signed [AW-1:0]             shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= i_x * i_f;
        r_clear <= i_ctl.clear;
        r_lsh   <= i_ctl.lsh;
        if (r_valid) begin
            r_acc <= (r_clear ? '0 : r_acc) + prod_sh;
        end
    end

    assign prod_sh = AW'(r_prod) <<< r_lsh;

    // ties round toward plus infinity: add half an lsb, then floor
    assign half    = AW'(1) <<< (i_rsh - dmnc_pkg::RSH_W'(1));
    assign rounded = r_acc + half;
    assign shifted = rounded >>> i_rsh;

    always_comb begin
        if (shifted > E_MAX) begin
            o_result = ELEMENT_BITS'(E_MAX);
        end else if (shifted < E_MIN) begin
            o_result = ELEMENT_BITS'(E_MIN);
        end else begin
            o_result = shifted[ELEMENT_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_density_matrix_noise_channel.sv @@
// testbench for density_matrix_noise_channel: fills the element store, walks a directed
// table, then random words under changing channel settings, checked against a local model
// depends on dmnc_pkg, dmnc_cmd_if, dmnc_res_if and the density_matrix_noise_channel top
module tb_density_matrix_noise_channel;
    timeunit 1ns;
    timeprecision 1ps;

    import dmnc_pkg::*;

    localparam int DIM_MAX       = 1 << MAX_QUBITS_DEF;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENTS      = 5;
    localparam int SEG_WORDS     = 50;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam longint ELEM_MAX = 64'sd2147483647;
    localparam longint ELEM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         row;
        logic [3:0]         column;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic signed [31:0] tr;
        logic               status;
    } res_word_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        t_reg        reg_idx;
        logic [31:0] reg_val;
        cmd_word_t   word;
        logic        typed;
        res_word_t   want;
    } table_row_t;

    typedef struct {
        int        seq;
        res_word_t res;
    } pending_t;

    localparam res_word_t RES_ZERO       = '0;
    localparam res_word_t RES_BAD_TARGET = {32'h0, 32'h0, 32'h0, 1'b1};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               res_ready = 1'b0;

    dmnc_cmd_if cmd_if ();
    dmnc_res_if res_if ();

    assign res_if.ready = res_ready;

    density_matrix_noise_channel u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the element store and the channel registers
    logic signed [31:0]  shadow_re [DIM_MAX][DIM_MAX];
    logic signed [31:0]  shadow_im [DIM_MAX][DIM_MAX];
    logic signed [31:0]  shadow_trace;
    logic [1:0]          cfg_kind;
    logic [2:0]          cfg_qubits;
    logic [1:0]          cfg_target;
    logic [FACTOR_W-1:0] cfg_strength;
    logic [FACTOR_W-1:0] cfg_coherence;

    pending_t   pending_results[$];
    table_row_t directed_rows[$];

    int err_count     = 0;
    int quiet_cycles  = 0;
    int sent_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic longint sat_elem(longint v);
        if (v > ELEM_MAX) return ELEM_MAX;
        if (v < ELEM_MIN) return ELEM_MIN;
        return v;
    endfunction

    // round to nearest, ties up, dropping s fraction bits
    function automatic longint round_drop(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint scale_q16(longint x, longint f);
        return sat_elem(round_drop(x * f, FACTOR_SHIFT));
    endfunction

    function automatic longint clamp_factor(logic [FACTOR_W-1:0] f);
        return (f > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(f);
    endfunction

    // updates the shadow store for one word and returns the result it should give
    function automatic res_word_t predict_response(cmd_word_t w);
        res_word_t r;
        int n, dim, ri, ci, t, i, j;
        longint g, cs, omp, sum, num;
        logic bi, bj;
        r   = '0;
        n   = (cfg_qubits > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(cfg_qubits);
        dim = 1 << n;
        ri  = int'(w.row) & (dim - 1);
        ci  = int'(w.column) & (dim - 1);
        g   = clamp_factor(cfg_strength);
        cs  = clamp_factor(cfg_coherence);
        omp = longint'(FACTOR_ONE) - g;
        case (w.command)
            CMD_WRITE: begin
                shadow_re[ri][ci] = w.re;
                shadow_im[ri][ci] = w.im;
            end
            CMD_READ: begin
                r.re = shadow_re[ri][ci];
                r.im = shadow_im[ri][ci];
            end
            CMD_APPLY: begin
                if (cfg_kind == KIND_DEPOL) begin
                    sum = 0;
                    for (i = 0; i < dim; i++) sum += longint'(shadow_re[i][i]);
                    shadow_trace = 32'(sat_elem(sum));
                    r.tr = shadow_trace;
                    for (i = 0; i < dim; i++) begin
                        for (j = 0; j < dim; j++) begin
                            if (i == j) begin
                                num = longint'(shadow_re[i][j]) * omp * dim
                                    + longint'(shadow_trace) * g;
                                shadow_re[i][j] = 32'(sat_elem(round_drop(num, FACTOR_SHIFT + n)));
                            end else begin
                                shadow_re[i][j] = 32'(scale_q16(shadow_re[i][j], omp));
                            end
                            shadow_im[i][j] = 32'(scale_q16(shadow_im[i][j], omp));
                        end
                    end
                end else if (cfg_kind == KIND_AMP || cfg_kind == KIND_PHASE) begin
                    if (int'(cfg_target) >= n) begin
                        r.status = 1'b1;
                    end else begin
                        t = 1 << cfg_target;
                        // both-set entries stay untouched until the second pass
                        for (i = 0; i < dim; i++) begin
                            for (j = 0; j < dim; j++) begin
                                bi = (i & t) != 0;
                                bj = (j & t) != 0;
                                if (bi != bj) begin
                                    shadow_re[i][j] = 32'(scale_q16(shadow_re[i][j], cs));
                                    shadow_im[i][j] = 32'(scale_q16(shadow_im[i][j], cs));
                                end else if (!bi && cfg_kind == KIND_AMP) begin
                                    num = longint'(shadow_re[i][j]) * longint'(FACTOR_ONE)
                                        + longint'(shadow_re[i | t][j | t]) * g;
                                    shadow_re[i][j] = 32'(sat_elem(round_drop(num, FACTOR_SHIFT)));
                                    num = longint'(shadow_im[i][j]) * longint'(FACTOR_ONE)
                                        + longint'(shadow_im[i | t][j | t]) * g;
                                    shadow_im[i][j] = 32'(sat_elem(round_drop(num, FACTOR_SHIFT)));
                                end
                            end
                        end
                        if (cfg_kind == KIND_AMP) begin
                            for (i = 0; i < dim; i++) begin
                                for (j = 0; j < dim; j++) begin
                                    if ((i & t) != 0 && (j & t) != 0) begin
                                        shadow_re[i][j] = 32'(scale_q16(shadow_re[i][j], omp));
                                        shadow_im[i][j] = 32'(scale_q16(shadow_im[i][j], omp));
                                    end
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t MISMATCH %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(int seq, string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %h want %h", seq, name, got, want));
    endtask

    // setup phase, access phase until pready, then an idle phase
    task automatic program_reg(t_reg idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_CHANNEL_KIND:    cfg_kind      = val[1:0];
            REG_QUBIT_COUNT:     cfg_qubits    = val[2:0];
            REG_TARGET_QUBIT:    cfg_target    = val[1:0];
            REG_STRENGTH:        cfg_strength  = val[FACTOR_W-1:0];
            REG_COHERENCE_SCALE: cfg_coherence = val[FACTOR_W-1:0];
            default: ;
        endcase
    endtask

    // block must be idle before registers change
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(cmd_word_t w, logic typed, res_word_t want);
        pending_t p;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= w.command;
        cmd_if.row     <= w.row;
        cmd_if.column  <= w.column;
        cmd_if.real_in <= w.re;
        cmd_if.imag_in <= w.im;
        do @(posedge i_clk); while (!cmd_if.ready);
        p.seq = sent_count;
        p.res = predict_response(w);
        if (typed) p.res = want;
        pending_results.push_back(p);
        sent_count++;
    endtask

    task automatic add_word(logic [1:0] cmd, int r, int c, logic [31:0] re, logic [31:0] im,
                            logic typed = 1'b0, res_word_t want = '0);
        table_row_t row;
        row.kind    = ROW_WORD;
        row.reg_idx = REG_CHANNEL_KIND;
        row.reg_val = '0;
        row.word    = {cmd, 4'(r), 4'(c), re, im};
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(t_reg idx, logic [31:0] val);
        table_row_t row;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.word    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 44) w.command = CMD_WRITE;
        else if (pick < 80) w.command = CMD_READ;
        else if (pick < 95) w.command = CMD_APPLY;
        else w.command = CMD_UNUSED;
        w.row    = 4'($urandom_range(0, 15));
        w.column = 4'($urandom_range(0, 15));
        w.re     = rand_elem();
        w.im     = rand_elem();
        return w;
    endfunction

    function automatic logic [31:0] rand_factor();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return $urandom_range(65537, 131071);
        if (pick < 20) return 32'(FACTOR_ONE);
        if (pick < 25) return 32'h0;
        return $urandom_range(0, 65535);
    endfunction

    // mostly small matrices, since an apply on the largest one is slow
    task automatic choose_channel_setting();
        int pick;
        logic [31:0] val;
        pick = $urandom_range(0, 9);
        if (pick < 3) val = 32'(KIND_DEPOL);
        else if (pick < 6) val = 32'(KIND_AMP);
        else if (pick < 9) val = 32'(KIND_PHASE);
        else val = 32'(KIND_UNUSED);
        program_reg(REG_CHANNEL_KIND, val);
        pick = $urandom_range(0, 99);
        if (pick < 5) val = 0;
        else if (pick < 40) val = 1;
        else if (pick < 75) val = 2;
        else if (pick < 90) val = 3;
        else if (pick < 95) val = 4;
        else val = $urandom_range(5, 7);
        program_reg(REG_QUBIT_COUNT, val);
        program_reg(REG_TARGET_QUBIT, $urandom_range(0, 3));
        program_reg(REG_STRENGTH, rand_factor());
        program_reg(REG_COHERENCE_SCALE, rand_factor());
    endtask

    always @(posedge i_clk) begin
        pending_t head;
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (i_rst_n && res_if.valid && res_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: re %h im %h tr %h st %b",
                                          res_if.real_out, res_if.imag_out, res_if.trace_out,
                                          res_if.status));
            end else begin
                head = pending_results.pop_front();
                check_field(head.seq, "real_out", res_if.real_out, head.res.re);
                check_field(head.seq, "imag_out", res_if.imag_out, head.res.im);
                check_field(head.seq, "trace_out", res_if.trace_out, head.res.tr);
                check_field(head.seq, "status", 32'(res_if.status), 32'(head.res.status));
            end
        end
        res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        cmd_word_t w;
        int r, c, k, phase, seg;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_WRITE;
        cmd_if.row     = '0;
        cmd_if.column  = '0;
        cmd_if.real_in = '0;
        cmd_if.imag_in = '0;
        cfg_kind       = KIND_DEPOL;
        cfg_qubits     = 3'd1;
        cfg_target     = 2'd0;
        cfg_strength   = '0;
        cfg_coherence  = FACTOR_ONE;
        shadow_trace   = '0;
        for (r = 0; r < DIM_MAX; r++) begin
            for (c = 0; c < DIM_MAX; c++) begin
                shadow_re[r][c] = '0;
                shadow_im[r][c] = '0;
            end
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every entry so no apply or read ever touches an unwritten one
        program_reg(REG_QUBIT_COUNT, 32'd4);
        for (r = 0; r < DIM_MAX; r++) begin
            for (c = 0; c < DIM_MAX; c++) begin
                w        = rand_word();
                w.command = CMD_WRITE;
                w.row    = 4'(r);
                w.column = 4'(c);
                send_word(w, 1'b0, RES_ZERO);
            end
        end

        // extremes and read-back
        add_word(CMD_WRITE, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1'b1, RES_ZERO);
        add_word(CMD_READ, 0, 0, 32'h0, 32'h0, 1'b1, {32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0});
        add_word(CMD_WRITE, 15, 15, 32'h8000_0000, 32'h7fff_ffff, 1'b1, RES_ZERO);
        add_word(CMD_READ, 15, 15, 32'h0, 32'h0, 1'b1, {32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0});
        add_word(CMD_UNUSED, 15, 15, 32'hffff_ffff, 32'hffff_ffff, 1'b1, RES_ZERO);
        // index wraps on a 2 x 2 matrix
        add_reg(REG_QUBIT_COUNT, 32'd1);
        add_word(CMD_WRITE, 15, 14, 32'h0, 32'hffff_ffff, 1'b1, RES_ZERO);
        add_word(CMD_READ, 1, 0, 32'h0, 32'h0, 1'b1, {32'h0, 32'hffff_ffff, 32'h0, 1'b0});
        // unused channel kind
        add_reg(REG_CHANNEL_KIND, 32'(KIND_UNUSED));
        add_word(CMD_APPLY, 0, 0, 32'h0, 32'h0, 1'b1, RES_ZERO);
        // target qubit out of range
        add_reg(REG_CHANNEL_KIND, 32'(KIND_AMP));
        add_reg(REG_TARGET_QUBIT, 32'd3);
        add_word(CMD_APPLY, 0, 0, 32'h0, 32'h0, 1'b1, RES_BAD_TARGET);
        // factors above one clamp
        add_reg(REG_TARGET_QUBIT, 32'd0);
        add_reg(REG_STRENGTH, 32'h1ffff);
        add_reg(REG_COHERENCE_SCALE, 32'h0);
        add_word(CMD_APPLY, 0, 0, 32'h0, 32'h0);
        add_word(CMD_READ, 0, 0, 32'h0, 32'h0);
        add_word(CMD_READ, 1, 1, 32'h0, 32'h0);
        // oversized qubit count, trace saturates
        add_reg(REG_CHANNEL_KIND, 32'(KIND_DEPOL));
        add_reg(REG_STRENGTH, 32'h8000);
        add_reg(REG_QUBIT_COUNT, 32'd7);
        add_word(CMD_WRITE, 0, 0, 32'h7fff_ffff, 32'h0, 1'b1, RES_ZERO);
        add_word(CMD_WRITE, 1, 1, 32'h7fff_ffff, 32'h0, 1'b1, RES_ZERO);
        add_word(CMD_WRITE, 2, 2, 32'h7fff_ffff, 32'h0, 1'b1, RES_ZERO);
        add_word(CMD_APPLY, 0, 0, 32'h0, 32'h0);
        add_word(CMD_READ, 5, 5, 32'h0, 32'h0);
        // single entry matrix
        add_reg(REG_QUBIT_COUNT, 32'd0);
        add_word(CMD_WRITE, 9, 3, 32'h4000_0000, 32'hc000_0000, 1'b1, RES_ZERO);
        add_word(CMD_APPLY, 0, 0, 32'h0, 32'h0);
        add_word(CMD_READ, 0, 0, 32'h0, 32'h0);
        add_reg(REG_CHANNEL_KIND, 32'(KIND_PHASE));
        add_reg(REG_QUBIT_COUNT, 32'd2);
        add_reg(REG_TARGET_QUBIT, 32'd1);
        add_reg(REG_COHERENCE_SCALE, 32'h1ffff);
        add_reg(REG_STRENGTH, 32'h0);
        add_word(CMD_APPLY, 0, 0, 32'h0, 32'h0);
        add_word(CMD_READ, 0, 2, 32'h0, 32'h0);
        // full damping
        add_reg(REG_CHANNEL_KIND, 32'(KIND_AMP));
        add_reg(REG_STRENGTH, 32'(FACTOR_ONE));
        add_reg(REG_COHERENCE_SCALE, 32'(FACTOR_ONE));
        add_word(CMD_APPLY, 0, 0, 32'h0, 32'h0);
        add_word(CMD_READ, 0, 0, 32'h0, 32'h0);
        add_word(CMD_READ, 3, 3, 32'h0, 32'h0);

        send_idle_pct = 21;
        recv_idle_pct = 63;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG) begin
                settle();
                program_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].want);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < SEGMENTS; seg++) begin
                settle();
                choose_channel_setting();
                for (k = 0; k < SEG_WORDS; k++) send_word(rand_word(), 1'b0, RES_ZERO);
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
